>>> rtl/core/wbps_pkg.sv
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types and constants for the wildcard byte pattern scanner: register
// map, field widths and parameter defaults.
// ----------------------------------------------------------------------------
package wbps_pkg;

   localparam int BYTE_W             = 8;
   localparam int MAX_PATTERN_DEF    = 16;
   localparam int POSITION_BITS_DEF  = 32;
   localparam int CSR_INDEX_W        = 3;
   localparam int CSR_DATA_W         = 64;
   localparam int PATTERN_WORD_W     = 64;
   localparam int CARE_MASK_W        = 16;
   localparam int PATTERN_LENGTH_W   = 5;
   localparam int START_OFFSET_W     = 32;
   localparam int MATCH_START_W      = 32;
   localparam int TOTAL_W            = 32;

   // Register map
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_LOW    = 3'd0,
      CSR_PATTERN_HIGH   = 3'd1,
      CSR_CARE_MASK      = 3'd2,
      CSR_PATTERN_LENGTH = 3'd3,
      CSR_START_OFFSET   = 3'd4,
      CSR_FIRST_ONLY     = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [PATTERN_WORD_W-1:0]   pattern_low;
      logic [PATTERN_WORD_W-1:0]   pattern_high;
      logic [CARE_MASK_W-1:0]      care_mask;
      logic [PATTERN_LENGTH_W-1:0] pattern_length;
      logic [START_OFFSET_W-1:0]   start_offset;
      logic                        first_only;
   } cfg_type;

endpackage

>>> rtl/core/wbps_match.sv
// ----------------------------------------------------------------------------
// wbps_match
// Window compare: checks the newest bytes of the stream against the pattern,
// with wildcard bytes matching anything. Purely combinational.
// ----------------------------------------------------------------------------
module wbps_match
   import wbps_pkg::*;
#(
   parameter int MAX_PATTERN_BYTES = MAX_PATTERN_DEF,
   parameter int LEN_W             = $clog2(MAX_PATTERN_BYTES + 1)
) (
   // history: byte 0 is the current byte, byte k the one k steps older
   input  logic [MAX_PATTERN_BYTES*BYTE_W-1:0] hist_bytes,
   input  logic [MAX_PATTERN_BYTES*BYTE_W-1:0] pattern_bytes,
   input  logic [MAX_PATTERN_BYTES-1:0]        care_bits,
   input  logic [LEN_W-1:0]                    len,
   output logic                                hit
);

   localparam int IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
   localparam int SUM_W = LEN_W + 1;

   logic [BYTE_W-1:0]            hist_arr [MAX_PATTERN_BYTES];
   logic [MAX_PATTERN_BYTES-1:0] byte_ok;

   // unpack the history into an indexable array
   for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_unpack
      assign hist_arr[k] = hist_bytes[k*BYTE_W +: BYTE_W];
   end

   // pattern byte i lines up with the byte len-1-i steps back
   for (genvar i = 0; i < MAX_PATTERN_BYTES; i++) begin : g_cmp
      logic [SUM_W-1:0] pick;
      logic             unused_slot;

      assign pick        = SUM_W'(len) - SUM_W'(1) - SUM_W'(i);
      assign unused_slot = SUM_W'(i) >= SUM_W'(len);
      assign byte_ok[i]  = !care_bits[i] || unused_slot ||
                           (hist_arr[pick[IDX_W-1:0]] == pattern_bytes[i*BYTE_W +: BYTE_W]);
   end

   assign hit = &byte_ok;

endmodule

>>> rtl/core/wildcard_byte_pattern_scan.sv
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scan
// Streaming search for a wildcard byte pattern of up to MAX_PATTERN_BYTES
// bytes, one buffer byte per word, one result word per byte.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one buffer byte per word, with req_last_byte on
//   the final byte of a buffer. The rsp_ channel returns one word per byte:
//   match flag and start position of a match ending on that byte, the
//   saturating match count of the buffer, the end-of-buffer mark and the
//   empty-pattern error flag.
//   From req accept to rsp valid, the byte is held in an
//   input register, then compared against the sliding window and pattern
//   and stored in the result register. Throughput is one byte per cycle
//   while the receiver does not stall; the window compare and counter
//   updates all happen combinationally between the two registers.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more byte; req_ready drops only when both are
//   full.
//   Reset clears the window, position, match count and all csr_ registers.
//   Write csr_ registers only while no byte is in flight.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scan
   import wbps_pkg::*;
#(
   parameter int MAX_PATTERN_BYTES = MAX_PATTERN_DEF,
   parameter int POSITION_BITS     = POSITION_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   // configuration
   input  logic                     csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_write_data,
   // input bytes
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [BYTE_W-1:0]        req_data_byte,
   input  logic                     req_last_byte,
   // results
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_match_found,
   output logic [MATCH_START_W-1:0] rsp_match_start,
   output logic [TOTAL_W-1:0]       rsp_match_total,
   output logic                     rsp_end_of_buffer,
   output logic                     rsp_empty_pattern_error
);

   localparam int LEN_W     = $clog2(MAX_PATTERN_BYTES + 1);
   localparam int WIN_DEPTH = (MAX_PATTERN_BYTES > 1) ? MAX_PATTERN_BYTES - 1 : 1;
   localparam int CMP_W     = (POSITION_BITS > START_OFFSET_W) ? POSITION_BITS
                                                                : START_OFFSET_W;
   localparam logic [PATTERN_LENGTH_W-1:0] LEN_MAX = PATTERN_LENGTH_W'(MAX_PATTERN_BYTES);

   // configuration registers
   cfg_type cfg_ff, cfg_in;

   // input stage
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_data_ff;
   logic              in_last_ff;

   // per-buffer state
   logic [BYTE_W-1:0]        window_ff [WIN_DEPTH];
   logic [BYTE_W-1:0]        window_in [WIN_DEPTH];
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [TOTAL_W-1:0]       total_ff, total_in;
   logic                     first_rep_ff, first_rep_in;

   // result stage
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     found_ff;
   logic [MATCH_START_W-1:0] start_ff;
   logic [TOTAL_W-1:0]       rsp_total_ff;
   logic                     eob_ff;
   logic                     err_ff;

   // datapath
   logic                                advance;
   logic                                req_fire;
   logic [LEN_W-1:0]                    len_clamp;
   logic [LEN_W-1:0]                    len_m1;
   logic                                empty;
   logic                                fits;
   logic [POSITION_BITS-1:0]            start_pos;
   logic                                offset_ok;
   logic                                hit;
   logic                                found;
   logic [TOTAL_W-1:0]                  total_next;
   logic [MAX_PATTERN_BYTES*BYTE_W-1:0] hist_bytes;
   logic [2*PATTERN_WORD_W-1:0]         pattern_all;

   // handshakes
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   // decode configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PATTERN_LOW:    cfg_in.pattern_low    = csr_write_data;
            CSR_PATTERN_HIGH:   cfg_in.pattern_high   = csr_write_data;
            CSR_CARE_MASK:      cfg_in.care_mask      = csr_write_data[CARE_MASK_W-1:0];
            CSR_PATTERN_LENGTH: cfg_in.pattern_length =
                                   csr_write_data[PATTERN_LENGTH_W-1:0];
            CSR_START_OFFSET:   cfg_in.start_offset   = csr_write_data[START_OFFSET_W-1:0];
            CSR_FIRST_ONLY:     cfg_in.first_only     = csr_write_data[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   // build history: current byte, then window newest first
   assign hist_bytes[BYTE_W-1:0] = in_data_ff;
   for (genvar k = 1; k < MAX_PATTERN_BYTES; k++) begin : g_hist
      assign hist_bytes[k*BYTE_W +: BYTE_W] = window_ff[k-1];
   end

   assign pattern_all = {cfg_ff.pattern_high, cfg_ff.pattern_low};

   // clamp length and check that the pattern fits
   assign len_clamp = (cfg_ff.pattern_length > LEN_MAX) ? LEN_W'(MAX_PATTERN_BYTES)
                                                        : cfg_ff.pattern_length[LEN_W-1:0];
   assign empty     = (cfg_ff.pattern_length == '0);
   assign len_m1    = len_clamp - LEN_W'(1);
   assign fits      = !empty && (pos_ff >= POSITION_BITS'(len_m1));
   assign start_pos = pos_ff - POSITION_BITS'(len_m1);
   assign offset_ok = CMP_W'(start_pos) >= CMP_W'(cfg_ff.start_offset);

   wbps_match #(
      .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES),
      .LEN_W            (LEN_W)
   ) u_match (
      .hist_bytes   (hist_bytes),
      .pattern_bytes(pattern_all[MAX_PATTERN_BYTES*BYTE_W-1:0]),
      .care_bits    (cfg_ff.care_mask[MAX_PATTERN_BYTES-1:0]),
      .len          (len_clamp),
      .hit          (hit)
   );

   assign found = fits && hit && offset_ok && !(cfg_ff.first_only && first_rep_ff);

   // count matches, saturating
   assign total_next = (found && (total_ff != '1)) ? total_ff + TOTAL_W'(1) : total_ff;

   // advance per-buffer state; drop it all at end of buffer
   always_comb begin
      window_in    = window_ff;
      pos_in       = pos_ff;
      total_in     = total_ff;
      first_rep_in = first_rep_ff;
      if (advance) begin
         if (in_last_ff) begin
            for (int k = 0; k < WIN_DEPTH; k++) begin
               window_in[k] = '0;
            end
            pos_in       = '0;
            total_in     = '0;
            first_rep_in = 1'b0;
         end else begin
            window_in[0] = in_data_ff;
            for (int k = 1; k < WIN_DEPTH; k++) begin
               window_in[k] = window_ff[k-1];
            end
            pos_in       = (pos_ff != '1) ? pos_ff + POSITION_BITS'(1) : pos_ff;
            total_in     = total_next;
            first_rep_in = first_rep_ff || (found && cfg_ff.first_only);
         end
      end
   end

   // stage valid bits
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         total_ff     <= '0;
         first_rep_ff <= 1'b0;
         for (int k = 0; k < WIN_DEPTH; k++) begin
            window_ff[k] <= '0;
         end
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         total_ff     <= total_in;
         first_rep_ff <= first_rep_in;
         window_ff    <= window_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
      if (advance) begin
         found_ff     <= found;
         start_ff     <= found ? MATCH_START_W'(start_pos) : '0;
         rsp_total_ff <= total_next;
         eob_ff       <= in_last_ff;
         err_ff       <= empty;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_match_found         = found_ff;
   assign rsp_match_start         = start_ff;
   assign rsp_match_total         = rsp_total_ff;
   assign rsp_end_of_buffer       = eob_ff;
   assign rsp_empty_pattern_error = err_ff;

   // an empty pattern never reports a match
   a_no_match_on_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && err_ff |-> !found_ff)
      else $error("match reported with empty pattern");

   // a reported match always shows up in the count
   a_match_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && found_ff |-> rsp_total_ff != '0)
      else $error("match reported with zero total");

   // end of buffer drops position and count
   a_eob_clears: assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> pos_ff == '0 && total_ff == '0 && !first_rep_ff)
      else $error("buffer state not cleared after last byte");

   // first-only mode reports at most one match per buffer
   a_first_only: assert property (@(posedge clock) disable iff (reset)
      advance && found && cfg_ff.first_only && !in_last_ff |=> first_rep_ff)
      else $error("first match not recorded");

endmodule

>>> tb/wildcard_byte_pattern_scan_tb.sv
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scan_tb
// Self-checking bench for the wildcard byte pattern scanner. A short table of
// directed words is run first: empty pattern, pattern fit, wildcard bytes,
// offset, first-only, an over-long length and all-ones patterns. Random
// buffers follow under changing register settings. Each result word is matched
// to a typed result or the in-bench scan predictor. Both channels idle at random.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scan_tb
   import wbps_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WINDOW_DEPTH  = MAX_PATTERN_DEF - 1;
   localparam int RANDOM_ITEMS  = 1750;
   localparam int SCAN_LATENCY  = 4;
   localparam int STALL_LIMIT   = 400;

   typedef struct packed {
      logic                     match_found;
      logic [MATCH_START_W-1:0] match_start;
      logic [TOTAL_W-1:0]       match_total;
      logic                     end_of_buffer;
      logic                     empty_error;
   } scan_result_type;

   typedef enum logic [1:0] {
      ROW_WRITE,
      ROW_PREDICTED,
      ROW_TYPED
   } row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      csr_index_type         index;
      logic [CSR_DATA_W-1:0] value;
      logic [BYTE_W-1:0]     data;
      logic                  last;
      scan_result_type       want;
   } stim_row_type;

   localparam scan_result_type NO_RESULT = '0;
   localparam int DIRECTED_COUNT = 35;

   // Directed words; typed results only where they follow at once
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // after reset: zero length
      '{ROW_TYPED, CSR_PATTERN_LOW, 64'd0, 8'h00, 1'b0, '{1'b0, 32'd0, 32'd0, 1'b0, 1'b1}},
      '{ROW_TYPED, CSR_PATTERN_LOW, 64'd0, 8'hFF, 1'b1, '{1'b0, 32'd0, 32'd0, 1'b1, 1'b1}},
      // pattern 41 ?? 43
      '{ROW_WRITE, CSR_PATTERN_LOW, 64'h0000_0000_0043_5A41, 8'h00, 1'b0, NO_RESULT},
      '{ROW_WRITE, CSR_CARE_MASK, 64'h5, 8'h00, 1'b0, NO_RESULT},
      '{ROW_WRITE, CSR_PATTERN_LENGTH, 64'd3, 8'h00, 1'b0, NO_RESULT},
      '{ROW_TYPED, CSR_PATTERN_LOW, 64'd0, 8'h41, 1'b0, '{1'b0, 32'd0, 32'd0, 1'b0, 1'b0}},
      '{ROW_TYPED, CSR_PATTERN_LOW, 64'd0, 8'h00, 1'b0, '{1'b0, 32'd0, 32'd0, 1'b0, 1'b0}},
      '{ROW_TYPED, CSR_PATTERN_LOW, 64'd0, 8'h43, 1'b0, '{1'b1, 32'd0, 32'd1, 1'b0, 1'b0}},
      '{ROW_PREDICTED, CSR_PATTERN_LOW, 64'd0, 8'h41, 1'b0, NO_RESULT},
      '{ROW_PREDICTED, CSR_PATTERN_LOW, 64'd0, 8'h41, 1'b0, NO_RESULT},
      '{ROW_PREDICTED, CSR_PATTERN_LOW, 64'd0, 8'h43, 1'b0, NO_RESULT},
      '{ROW_PREDICTED, CSR_PATTERN_LOW, 64'd0, 8'h43, 1'b1, NO_RESULT},
      // first-only with a start offset
      '{ROW_WRITE, CSR_FIRST_ONLY, 64'd1, 8'h00, 1'b0, NO_RESULT},
      '{ROW_WRITE, CSR_START_OFFSET, 64'd2, 8'h00, 1'b0, NO_RESULT},
      '{ROW_PREDICTED, CSR_PATTERN_LOW, 64'd0, 8'h41, 1'b0, NO_RESULT},
      '{ROW_PREDICTED, CSR_PATTERN_LOW, 64'd0, 8'h41, 1'b0, NO_RESULT},
      '{ROW_PREDICTED, CSR_PATTERN_LOW, 64'd0, 8'h43, 1'b0, NO_RESULT},
      '{ROW_PREDICTED, CSR_PATTERN_LOW, 64'd0, 8'h43, 1'b0, NO_RESULT},
      '{ROW_PREDICTED, CSR_PATTERN_LOW, 64'd0, 8'h41, 1'b0, NO_RESULT},
      '{ROW_PREDICTED, CSR_PATTERN_LOW, 64'd0, 8'h41, 1'b0, NO_RESULT},
      '{ROW_PREDICTED, CSR_PATTERN_LOW, 64'd0, 8'h43, 1'b0, NO_RESULT},
      '{ROW_PREDICTED, CSR_PATTERN_LOW, 64'd0, 8'h43, 1'b1, NO_RESULT},
      // over-long length clips to the full width, one byte never fits
      '{ROW_WRITE, CSR_PATTERN_LENGTH, 64'd31, 8'h00, 1'b0, NO_RESULT},
      '{ROW_WRITE, CSR_CARE_MASK, 64'd0, 8'h00, 1'b0, NO_RESULT},
      '{ROW_WRITE, CSR_FIRST_ONLY, 64'd0, 8'h00, 1'b0, NO_RESULT},
      '{ROW_WRITE, CSR_START_OFFSET, 64'd0, 8'h00, 1'b0, NO_RESULT},
      '{ROW_TYPED, CSR_PATTERN_LOW, 64'd0, 8'hFF, 1'b1, '{1'b0, 32'd0, 32'd0, 1'b1, 1'b0}},
      // single fixed byte FF
      '{ROW_WRITE, CSR_PATTERN_LOW, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, NO_RESULT},
      '{ROW_WRITE, CSR_PATTERN_LENGTH, 64'd1, 8'h00, 1'b0, NO_RESULT},
      '{ROW_WRITE, CSR_CARE_MASK, 64'd1, 8'h00, 1'b0, NO_RESULT},
      '{ROW_TYPED, CSR_PATTERN_LOW, 64'd0, 8'hFF, 1'b0, '{1'b1, 32'd0, 32'd1, 1'b0, 1'b0}},
      '{ROW_TYPED, CSR_PATTERN_LOW, 64'd0, 8'h00, 1'b0, '{1'b0, 32'd0, 32'd1, 1'b0, 1'b0}},
      '{ROW_TYPED, CSR_PATTERN_LOW, 64'd0, 8'hFF, 1'b1, '{1'b1, 32'd2, 32'd2, 1'b1, 1'b0}},
      // back to an empty pattern
      '{ROW_WRITE, CSR_PATTERN_LENGTH, 64'd0, 8'h00, 1'b0, NO_RESULT},
      '{ROW_TYPED, CSR_PATTERN_LOW, 64'd0, 8'hFF, 1'b1, '{1'b0, 32'd0, 32'd0, 1'b1, 1'b1}}
   };

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_write_enable = 1'b0;
   csr_index_type            csr_index = CSR_PATTERN_LOW;
   logic [CSR_DATA_W-1:0]    csr_write_data = '0;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [BYTE_W-1:0]        req_data_byte = '0;
   logic                     req_last_byte = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic                     rsp_match_found;
   logic [MATCH_START_W-1:0] rsp_match_start;
   logic [TOTAL_W-1:0]       rsp_match_total;
   logic                     rsp_end_of_buffer;
   logic                     rsp_empty_pattern_error;

   wildcard_byte_pattern_scan dut (
      .clock                  (clock),
      .reset                  (reset),
      .csr_write_enable       (csr_write_enable),
      .csr_index              (csr_index),
      .csr_write_data         (csr_write_data),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_data_byte          (req_data_byte),
      .req_last_byte          (req_last_byte),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_match_found        (rsp_match_found),
      .rsp_match_start        (rsp_match_start),
      .rsp_match_total        (rsp_match_total),
      .rsp_end_of_buffer      (rsp_end_of_buffer),
      .rsp_empty_pattern_error(rsp_empty_pattern_error)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Shadow registers and scan state of the predictor
   cfg_type                  shadow_cfg = '0;
   logic [BYTE_W-1:0]        scan_window [WINDOW_DEPTH];
   logic [MATCH_START_W-1:0] scan_position;
   logic [TOTAL_W-1:0]       scan_total;
   logic                     first_seen;

   scan_result_type expected_results [$];
   scan_result_type observed;
   scan_result_type awaited;
   int unsigned     failures = 0;
   int unsigned     quiet_cycles = 0;
   bit              sender_idles = 1'b1;
   bit              receiver_idles = 1'b1;

   function automatic void clear_scan_state();
      for (int k = 0; k < WINDOW_DEPTH; k++) begin
         scan_window[k] = '0;
      end
      scan_position = '0;
      scan_total    = '0;
      first_seen    = 1'b0;
   endfunction

   function automatic void note_failure(input string what);
      if (failures < 10) begin
         $display("%s", what);
      end
      failures++;
   endfunction

   // Scan one byte: compare the window against the pattern, then advance
   function automatic scan_result_type scan_byte(input logic [BYTE_W-1:0] data,
                                                 input logic last);
      scan_result_type          res;
      logic [127:0]             pattern_bits;
      logic [MATCH_START_W-1:0] start_pos;
      logic [BYTE_W-1:0]        seen;
      int                       span;
      bit                       empty;
      bit                       hit;
      pattern_bits = {shadow_cfg.pattern_high, shadow_cfg.pattern_low};
      span  = int'(shadow_cfg.pattern_length);
      empty = (span == 0);
      if (span > MAX_PATTERN_DEF) begin
         span = MAX_PATTERN_DEF;
      end
      res = '0;
      hit = 1'b0;
      start_pos = '0;
      if (!empty && ({1'b0, scan_position} + 33'd1 >= 33'(span))) begin
         start_pos = scan_position + 32'd1 - 32'(span);
         hit = 1'b1;
         for (int i = 0; i < span; i++) begin
            if (shadow_cfg.care_mask[i]) begin
               seen = (i == span - 1) ? data : scan_window[span - 2 - i];
               if (seen != pattern_bits[8*i +: 8]) begin
                  hit = 1'b0;
               end
            end
         end
         hit = hit && (start_pos >= shadow_cfg.start_offset)
               && !(shadow_cfg.first_only && first_seen);
      end
      if (hit) begin
         if (scan_total != '1) begin
            scan_total++;
         end
         if (shadow_cfg.first_only) begin
            first_seen = 1'b1;
         end
      end else begin
         start_pos = '0;
      end
      res.match_found   = hit;
      res.match_start   = start_pos;
      res.match_total   = scan_total;
      res.end_of_buffer = last;
      res.empty_error   = empty;
      // drop the buffer on its last byte, otherwise shift the byte in
      if (last) begin
         clear_scan_state();
      end else begin
         for (int k = WINDOW_DEPTH - 1; k > 0; k--) begin
            scan_window[k] = scan_window[k-1];
         end
         scan_window[0] = data;
         if (scan_position != '1) begin
            scan_position++;
         end
      end
      return res;
   endfunction

   // Hold the sender until every result word is back and the pipe is empty
   task automatic drain_scan();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (SCAN_LATENCY) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type index,
                                 input logic [CSR_DATA_W-1:0] value);
      drain_scan();
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (index)
         CSR_PATTERN_LOW:    shadow_cfg.pattern_low    = value;
         CSR_PATTERN_HIGH:   shadow_cfg.pattern_high   = value;
         CSR_CARE_MASK:      shadow_cfg.care_mask      = value[CARE_MASK_W-1:0];
         CSR_PATTERN_LENGTH: shadow_cfg.pattern_length = value[PATTERN_LENGTH_W-1:0];
         CSR_START_OFFSET:   shadow_cfg.start_offset   = value[START_OFFSET_W-1:0];
         CSR_FIRST_ONLY:     shadow_cfg.first_only     = value[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Offer one byte word after a random gap and queue its expected result
   task automatic send_scan_byte(input logic [BYTE_W-1:0] data, input logic last,
                                 input bit typed, input scan_result_type want);
      int unsigned     gap;
      scan_result_type predicted;
      if ($urandom_range(0, 29) == 0) begin
         sender_idles = !sender_idles;
      end
      gap = sender_idles ? $urandom_range(0, 12) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= data;
      req_last_byte <= last;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      predicted = scan_byte(data, last);
      expected_results.insert(expected_results.size(), typed ? want : predicted);
   endtask

   // Result side: stall for a random gap before each word while idling
   initial begin : result_sink
      int unsigned stall;
      while (reset) begin
         @(posedge clock);
      end
      forever begin
         if ($urandom_range(0, 29) == 0) begin
            receiver_idles = !receiver_idles;
         end
         stall = receiver_idles ? $urandom_range(0, 12) : 0;
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) begin
            @(posedge clock);
         end
      end
   end

   // Match each result word against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         observed = {rsp_match_found, rsp_match_start, rsp_match_total,
                     rsp_end_of_buffer, rsp_empty_pattern_error};
         if (expected_results.size() == 0) begin
            note_failure($sformatf("unexpected result word: found=%0d start=%0d total=%0d",
                                   observed.match_found, observed.match_start,
                                   observed.match_total));
         end else begin
            awaited = expected_results.pop_front();
            if (observed !== awaited) begin
               note_failure($sformatf({"mismatch: expected found=%0d start=%0d total=%0d ",
                                       "eob=%0d err=%0d, got found=%0d start=%0d ",
                                       "total=%0d eob=%0d err=%0d"},
                                      awaited.match_found, awaited.match_start,
                                      awaited.match_total, awaited.end_of_buffer,
                                      awaited.empty_error, observed.match_found,
                                      observed.match_start, observed.match_total,
                                      observed.end_of_buffer, observed.empty_error));
            end
         end
      end
   end

   // Watchdog: end the run when no word moves for too long
   always @(posedge clock) begin
      if (reset || csr_write_enable || (req_valid && req_ready) || (rsp_valid && rsp_ready))
      begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("wildcard_byte_pattern_scan_tb failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [BYTE_W-1:0]     scan_buffer [$];
      logic [127:0]          pattern_bits;
      logic [CSR_DATA_W-1:0] low_word, high_word, care_word;
      logic [CSR_DATA_W-1:0] length_word, offset_word, first_word;
      int unsigned           phase, items_sent, buffer_bytes, used_len, pick, base;
      phase      = 0;
      items_sent = 0;
      clear_scan_state();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int r = 0; r < DIRECTED_COUNT; r++) begin
         if (DIRECTED_ROWS[r].kind == ROW_WRITE) begin
            write_register(DIRECTED_ROWS[r].index, DIRECTED_ROWS[r].value);
         end else begin
            send_scan_byte(DIRECTED_ROWS[r].data, DIRECTED_ROWS[r].last,
                           DIRECTED_ROWS[r].kind == ROW_TYPED, DIRECTED_ROWS[r].want);
         end
      end

      // random phases: new settings, then a few buffers
      while (items_sent < RANDOM_ITEMS) begin
         if (phase == 0) begin
            low_word    = '1;
            high_word   = '1;
            care_word   = 64'hFFFF;
            length_word = 64'd16;
            offset_word = 64'd0;
            first_word  = 64'd0;
         end else if (phase == 1) begin
            low_word    = '0;
            high_word   = '0;
            care_word   = '0;
            length_word = 64'd31;
            offset_word = 64'hFFFF_FFFF;
            first_word  = 64'd1;
         end else begin
            low_word  = {$urandom, $urandom};
            high_word = {$urandom, $urandom};
            care_word = {$urandom, $urandom};
            pick = $urandom_range(0, 3);
            if (pick == 0) begin
               care_word[CARE_MASK_W-1:0] = '0;
            end else if (pick == 1) begin
               care_word[CARE_MASK_W-1:0] = '1;
            end
            length_word = {$urandom, $urandom};
            pick = $urandom_range(0, 9);
            length_word[PATTERN_LENGTH_W-1:0] = (pick == 0) ? 5'd0 :
                                                (pick == 1) ? 5'd16 :
                                                (pick == 2) ? 5'($urandom_range(17, 31)) :
                                                5'($urandom_range(1, 6));
            offset_word = {$urandom, $urandom};
            pick = $urandom_range(0, 7);
            if (pick == 0) begin
               offset_word[31:0] = '1;
            end else if (pick >= 4) begin
               offset_word[31:0] = '0;
            end else if (pick >= 2) begin
               offset_word[31:0] = $urandom_range(1, 20);
            end
            first_word = {$urandom, $urandom};
         end
         write_register(CSR_PATTERN_LOW, low_word);
         write_register(CSR_PATTERN_HIGH, high_word);
         write_register(CSR_CARE_MASK, care_word);
         write_register(CSR_PATTERN_LENGTH, length_word);
         write_register(CSR_START_OFFSET, offset_word);
         write_register(CSR_FIRST_ONLY, first_word);

         pattern_bits = {shadow_cfg.pattern_high, shadow_cfg.pattern_low};
         used_len = 32'(shadow_cfg.pattern_length);
         if (used_len == 0 || used_len > MAX_PATTERN_DEF) begin
            used_len = MAX_PATTERN_DEF;
         end

         repeat ($urandom_range(1, 4)) begin
            buffer_bytes = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 120)
                                                        : $urandom_range(1, 30);
            scan_buffer.delete();
            // mostly whole pattern copies and pattern bytes, some noise
            while (scan_buffer.size() < buffer_bytes) begin
               pick = $urandom_range(0, 9);
               if (pick <= 3) begin
                  base = scan_buffer.size();
                  for (int k = 0; k < used_len; k++) begin
                     scan_buffer.insert(scan_buffer.size(),
                                        shadow_cfg.care_mask[k] ? pattern_bits[8*k +: 8]
                                                                : 8'($urandom));
                  end
                  // break one byte of the copy
                  if (pick == 0) begin
                     base = base + $urandom_range(0, used_len - 1);
                     scan_buffer[base] = ~scan_buffer[base];
                  end
               end else if (pick <= 6) begin
                  scan_buffer.insert(scan_buffer.size(),
                                     pattern_bits[8*$urandom_range(0, used_len - 1) +: 8]);
               end else begin
                  scan_buffer.insert(scan_buffer.size(), 8'($urandom));
               end
            end
            for (int k = 0; k < scan_buffer.size(); k++) begin
               send_scan_byte(scan_buffer[k], k == scan_buffer.size() - 1, 1'b0, NO_RESULT);
               items_sent++;
               if ($urandom_range(0, 99) == 0) begin
                  drain_scan();
               end
            end
         end
         phase++;
      end

      drain_scan();
      repeat (8) @(posedge clock);
      if (expected_results.size() != 0) begin
         note_failure("result words still outstanding at end of run");
      end
      if (failures == 0) begin
         $display("wildcard_byte_pattern_scan_tb passed");
      end else begin
         $display("wildcard_byte_pattern_scan_tb failed");
      end
      $finish;
   end

endmodule
